// ----- sv/crp_pkg.sv -----
// ----------------------------------------------------------------------------
// crp_pkg: shared types and constants of the range partition block
// Holds the store geometry, the function codes, the entry, item, memory
// request and result types, and the small pointer helpers.
// ----------------------------------------------------------------------------
package crp_pkg;

    // Store geometry and field widths.
    localparam int STORE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(STORE_DEPTH);
    localparam int ROW_WIDTH   = 32;
    localparam int KEY_W       = 64;
    localparam int FUNC_W      = 2;
    localparam int POS_W       = 10;
    localparam int PTR_W       = IDX_W + 2;

    // Function codes carried by an input beat.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_CRACK = 2'd1,
        FUNC_READ  = 2'd2
    } t_func;

    // Signed pointer wide enough for minus one up to the store depth.
    typedef logic signed [PTR_W-1:0] t_ptr;

    // One stored entry.
    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [ROW_WIDTH-1:0]    row;
    } t_entry;

    // One accepted input beat.
    typedef struct packed {
        logic [FUNC_W-1:0]       func;
        logic [IDX_W-1:0]        entry_index;
        logic signed [KEY_W-1:0] entry_key;
        logic [ROW_WIDTH-1:0]    entry_row;
        logic [POS_W-1:0]        range_low;
        logic [POS_W-1:0]        range_high;
        logic signed [KEY_W-1:0] pivot;
    } t_item;

    // Request to the entry store: one write and one read port.
    typedef struct packed {
        logic       wr_en;
        logic [IDX_W-1:0] wr_addr;
        t_entry     wr_data;
        logic       rd_en;
        logic [IDX_W-1:0] rd_addr;
    } t_mem_req;

    // Finished result handed to the output register.
    typedef struct packed {
        logic                    valid;
        logic signed [KEY_W-1:0] read_key;
        logic [ROW_WIDTH-1:0]    read_row;
        logic [POS_W-1:0]        split_pos;
    } t_result;

    // Range bound saturated at the last store position.
    function automatic t_ptr clamp_pos(input logic [POS_W-1:0] v);
        t_ptr p;
        if (int'(v) > STORE_DEPTH - 1) begin
            p = PTR_W'(STORE_DEPTH - 1);
        end else begin
            p = t_ptr'({{(PTR_W - POS_W){1'b0}}, v});
        end
        return p;
    endfunction

    // Final left pointer minus one, clamped at zero.
    function automatic logic [POS_W-1:0] split_of(input t_ptr l);
        t_ptr d;
        d = l - t_ptr'(1);
        if (d < 0) begin
            return '0;
        end
        return d[POS_W-1:0];
    endfunction

endpackage

// ----- sv/crack_range_partition.sv -----
// ----------------------------------------------------------------------------
// crack_range_partition: key and row id store with a range partition step
// Top level: input packing, entry store, sequencer and output register.
// ----------------------------------------------------------------------------
// The block holds 1024 entries of a signed 64-bit key and a 32-bit row id in
// one memory with a single write and a single registered read port. A write
// beat passes through the start and done states, and a read beat through
// the start, read and done states. A crack beat partitions the inclusive
// range around the pivot with a two-pointer walk driven by one sequencer and
// one shared key comparator: each entry inspected by either pointer is first
// addressed, then compared, and a swap writes its first entry in the cycle
// of the compare and its second entry from the swap state that follows.
// Input is held off until the result has been produced; a finished result
// waits in the output register while the next beat is accepted.
module crack_range_partition (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [crp_pkg::FUNC_W-1:0]          i_func,
    input  logic [crp_pkg::IDX_W-1:0]           i_entry_index,
    input  logic signed [crp_pkg::KEY_W-1:0]    i_entry_key,
    input  logic [crp_pkg::ROW_WIDTH-1:0]       i_entry_row,
    input  logic [crp_pkg::POS_W-1:0]           i_range_low,
    input  logic [crp_pkg::POS_W-1:0]           i_range_high,
    input  logic signed [crp_pkg::KEY_W-1:0]    i_pivot,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [crp_pkg::KEY_W-1:0]    o_read_key,
    output logic [crp_pkg::ROW_WIDTH-1:0]       o_read_row,
    output logic [crp_pkg::POS_W-1:0]           o_split_pos
);
    import crp_pkg::*;

    t_item    item;
    t_result  result;
    t_mem_req mem_req;
    t_entry   rd_data;
    logic     out_free;

    logic                    r_out_valid;
    logic signed [KEY_W-1:0] r_out_key;
    logic [ROW_WIDTH-1:0]    r_out_row;
    logic [POS_W-1:0]        r_out_split;

    // Gather the input beat.
    always_comb begin
        item.func        = i_func;
        item.entry_index = i_entry_index;
        item.entry_key   = i_entry_key;
        item.entry_row   = i_entry_row;
        item.range_low   = i_range_low;
        item.range_high  = i_range_high;
        item.pivot       = i_pivot;
    end

    crp_store u_store (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    crp_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_item     (item),
        .i_out_free (out_free),
        .o_result   (result),
        .o_mem_req  (mem_req),
        .i_rd_data  (rd_data)
    );

    // The output slot may be refilled in the cycle its beat is taken.
    assign out_free = !r_out_valid || i_ready;

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (result.valid) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (result.valid) begin
            r_out_key   <= result.read_key;
            r_out_row   <= result.read_row;
            r_out_split <= result.split_pos;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_read_key  = r_out_key;
    assign o_read_row  = r_out_row;
    assign o_split_pos = r_out_split;

endmodule

// ----- sv/crp_store.sv -----
// ----------------------------------------------------------------------------
// crp_store: entry store of the range partition block
// Single-port-write, single-port-read memory of key and row id entries with
// registered read data.
// ----------------------------------------------------------------------------
module crp_store (
    input  logic              i_clk,
    input  crp_pkg::t_mem_req i_req,
    output crp_pkg::t_entry   o_rd_data
);
    import crp_pkg::*;

    t_entry r_mem [STORE_DEPTH];
    t_entry r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    // Read port, data valid the cycle after the address.
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- sv/crp_seq.sv -----
// ----------------------------------------------------------------------------
// crp_seq: sequencer of the range partition block
// Runs writes, reads and the two-pointer partition over the entry store,
// sharing one signed key comparator across both pointer scans.
// ----------------------------------------------------------------------------
module crp_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  crp_pkg::t_item    i_item,
    input  logic              i_out_free,
    output crp_pkg::t_result  o_result,
    output crp_pkg::t_mem_req o_mem_req,
    input  crp_pkg::t_entry   i_rd_data
);
    import crp_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_START = 8'b0000_0010,
        S_RD    = 8'b0000_0100,
        S_LOOP  = 8'b0000_1000,
        S_CHKL  = 8'b0001_0000,
        S_RSCAN = 8'b0010_0000,
        S_CHKR  = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    // The swap's second write has its own state flag beside the main state.
    typedef enum logic {
        SW_OFF = 1'b0,
        SW_ON  = 1'b1
    } t_swap;

    t_state r_state, n_state;
    t_swap  r_swap, n_swap;
    t_ptr   r_l, n_l;
    t_ptr   r_r, n_r;
    t_item  r_item, n_item;
    t_entry r_ent_l, n_ent_l;
    logic signed [KEY_W-1:0] r_res_key, n_res_key;
    logic [ROW_WIDTH-1:0]    r_res_row, n_res_row;
    logic [POS_W-1:0]        r_res_split, n_res_split;
    logic   key_lt;

    // Shared comparator: the entry just read against the pivot.
    assign key_lt = $signed(i_rd_data.key) < $signed(r_item.pivot);

    assign o_ready = (r_state == S_IDLE);

    // Next-state and datapath control.
    always_comb begin
        n_state     = r_state;
        n_swap      = r_swap;
        n_l         = r_l;
        n_r         = r_r;
        n_item      = r_item;
        n_ent_l     = r_ent_l;
        n_res_key   = r_res_key;
        n_res_row   = r_res_row;
        n_res_split = r_res_split;
        o_mem_req   = '0;
        o_result    = '0;

        if (r_swap == SW_ON) begin
            // Second half of a swap: old left entry goes to the right slot.
            o_mem_req.wr_en   = 1'b1;
            o_mem_req.wr_addr = r_r[IDX_W-1:0];
            o_mem_req.wr_data = r_ent_l;
            n_l               = r_l + t_ptr'(1);
            n_r               = r_r - t_ptr'(1);
            n_swap            = SW_OFF;
            n_state           = S_LOOP;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        n_item  = i_item;
                        n_state = S_START;
                    end
                end
                S_START: begin
                    n_res_key   = '0;
                    n_res_row   = '0;
                    n_res_split = '0;
                    case (r_item.func)
                        FUNC_WRITE: begin
                            o_mem_req.wr_en       = 1'b1;
                            o_mem_req.wr_addr     = r_item.entry_index;
                            o_mem_req.wr_data.key = r_item.entry_key;
                            o_mem_req.wr_data.row = r_item.entry_row;
                            n_state               = S_DONE;
                        end
                        FUNC_READ: begin
                            o_mem_req.rd_en   = 1'b1;
                            o_mem_req.rd_addr = r_item.entry_index;
                            n_state           = S_RD;
                        end
                        FUNC_CRACK: begin
                            n_l     = clamp_pos(r_item.range_low);
                            n_r     = clamp_pos(r_item.range_high);
                            n_state = S_LOOP;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
                S_RD: begin
                    n_res_key = i_rd_data.key;
                    n_res_row = i_rd_data.row;
                    n_state   = S_DONE;
                end
                S_LOOP: begin
                    if (r_l > r_r) begin
                        n_res_split = split_of(r_l);
                        n_state     = S_DONE;
                    end else begin
                        o_mem_req.rd_en   = 1'b1;
                        o_mem_req.rd_addr = r_l[IDX_W-1:0];
                        n_state           = S_CHKL;
                    end
                end
                S_CHKL: begin
                    n_ent_l = i_rd_data;
                    if (key_lt) begin
                        n_l     = r_l + t_ptr'(1);
                        n_state = S_LOOP;
                    end else begin
                        n_state = S_RSCAN;
                    end
                end
                S_RSCAN: begin
                    if (r_r >= r_l) begin
                        o_mem_req.rd_en   = 1'b1;
                        o_mem_req.rd_addr = r_r[IDX_W-1:0];
                        n_state           = S_CHKR;
                    end else begin
                        n_state = S_LOOP;
                    end
                end
                S_CHKR: begin
                    if (!key_lt) begin
                        n_r     = r_r - t_ptr'(1);
                        n_state = S_RSCAN;
                    end else begin
                        // Right entry is below the pivot and lies past left.
                        o_mem_req.wr_en   = 1'b1;
                        o_mem_req.wr_addr = r_l[IDX_W-1:0];
                        o_mem_req.wr_data = i_rd_data;
                        n_swap            = SW_ON;
                    end
                end
                S_DONE: begin
                    if (i_out_free) begin
                        o_result.valid     = 1'b1;
                        o_result.read_key  = r_res_key;
                        o_result.read_row  = r_res_row;
                        o_result.split_pos = r_res_split;
                        n_state            = S_IDLE;
                    end
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_swap  <= SW_OFF;
            r_l     <= '0;
            r_r     <= '0;
        end else begin
            r_state <= n_state;
            r_swap  <= n_swap;
            r_l     <= n_l;
            r_r     <= n_r;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_item      <= n_item;
        r_ent_l     <= n_ent_l;
        r_res_key   <= n_res_key;
        r_res_row   <= n_res_row;
        r_res_split <= n_res_split;
    end

endmodule

// ----- bench/crp_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crp_checker: result checker for the range partition block
// Watches the input and result channels, keeps its own copy of the entry
// store, works out the answer of every accepted input beat and compares
// each accepted result beat with the oldest answer still awaited.
// ----------------------------------------------------------------------------
module crp_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  logic [crp_pkg::FUNC_W-1:0]          i_func,
    input  logic [crp_pkg::IDX_W-1:0]           i_entry_index,
    input  logic signed [crp_pkg::KEY_W-1:0]    i_entry_key,
    input  logic [crp_pkg::ROW_WIDTH-1:0]       i_entry_row,
    input  logic [crp_pkg::POS_W-1:0]           i_range_low,
    input  logic [crp_pkg::POS_W-1:0]           i_range_high,
    input  logic signed [crp_pkg::KEY_W-1:0]    i_pivot,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  logic signed [crp_pkg::KEY_W-1:0]    i_read_key,
    input  logic [crp_pkg::ROW_WIDTH-1:0]       i_read_row,
    input  logic [crp_pkg::POS_W-1:0]           i_split_pos,
    output int                                  o_fail_count,
    output int                                  o_pending
);
    import crp_pkg::*;

    // One answer as it should appear on the result channel.
    typedef struct packed {
        logic signed [KEY_W-1:0] read_key;
        logic [ROW_WIDTH-1:0]    read_row;
        logic [POS_W-1:0]        split_pos;
    } t_answer;

    // Shadow copy of the entry store.
    logic signed [KEY_W-1:0] key_copy [STORE_DEPTH];
    logic [ROW_WIDTH-1:0]    row_copy [STORE_DEPTH];

    t_answer awaited_answers [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Applies one input beat to the shadow store and returns its answer.
    // A crack walks the range with the branched two-pointer scheme.
    function automatic t_answer predict_answer(input t_item beat);
        t_answer                 ans;
        int                      l;
        int                      r;
        logic signed [KEY_W-1:0] k;
        logic [ROW_WIDTH-1:0]    w;
        ans = '0;
        case (beat.func)
            FUNC_WRITE: begin
                key_copy[beat.entry_index] = beat.entry_key;
                row_copy[beat.entry_index] = beat.entry_row;
            end
            FUNC_CRACK: begin
                // Bounds saturate at the last store position.
                l = (int'(beat.range_low) > STORE_DEPTH - 1) ?
                    STORE_DEPTH - 1 : int'(beat.range_low);
                r = (int'(beat.range_high) > STORE_DEPTH - 1) ?
                    STORE_DEPTH - 1 : int'(beat.range_high);
                while (l <= r) begin
                    if (key_copy[l] < beat.pivot) begin
                        l++;
                    end else begin
                        while (r >= l && key_copy[r] >= beat.pivot) r--;
                        if (l < r) begin
                            k           = key_copy[l];
                            w           = row_copy[l];
                            key_copy[l] = key_copy[r];
                            row_copy[l] = row_copy[r];
                            key_copy[r] = k;
                            row_copy[r] = w;
                            l++;
                            r--;
                        end
                    end
                end
                // Final left pointer minus one, never below zero.
                ans.split_pos = (l - 1 < 0) ? '0 : POS_W'(l - 1);
            end
            FUNC_READ: begin
                ans.read_key = key_copy[beat.entry_index];
                ans.read_row = row_copy[beat.entry_index];
            end
            default: begin
            end
        endcase
        return ans;
    endfunction

    // Reports one field of a result beat that differs from its answer.
    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, want, got);
            o_fail_count++;
        end
    endtask

    // Result beats are compared before the input beat of the same edge is
    // predicted, since a result always belongs to an earlier input beat.
    always @(posedge i_clk) begin : watch_channels
        t_answer want;
        t_item   beat;
        if (!i_rst_n) begin
            awaited_answers.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (awaited_answers.size() == 0) begin
                    $display("%0t: stray result, expected none, actual %0h %0h %0h",
                             $time, i_read_key, i_read_row, i_split_pos);
                    o_fail_count++;
                end else begin
                    want = awaited_answers.pop_front();
                    check_field("read_key", want.read_key, i_read_key);
                    check_field("read_row", 64'(want.read_row), 64'(i_read_row));
                    check_field("split_pos", 64'(want.split_pos), 64'(i_split_pos));
                end
            end
            if (i_in_valid && i_in_ready) begin
                beat.func        = i_func;
                beat.entry_index = i_entry_index;
                beat.entry_key   = i_entry_key;
                beat.entry_row   = i_entry_row;
                beat.range_low   = i_range_low;
                beat.range_high  = i_range_high;
                beat.pivot       = i_pivot;
                awaited_answers.push_back(predict_answer(beat));
            end
        end
        o_pending = awaited_answers.size();
    end

endmodule

// ----- bench/tb_crack_range_partition.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_crack_range_partition: regression bench for the range partition block
// Drives writes, reads, cracks and unused function beats with random gaps
// on both channels; a checker beside the block predicts and compares every
// result. Reads and cracks only ever touch entries that have been written.
// ----------------------------------------------------------------------------
module tb_crack_range_partition;

    import crp_pkg::*;

    localparam logic [FUNC_W-1:0]       FUNC_UNUSED   = 2'd3;
    localparam logic signed [KEY_W-1:0] KEY_MIN       = {1'b1, {(KEY_W-1){1'b0}}};
    localparam logic signed [KEY_W-1:0] KEY_MAX       = {1'b0, {(KEY_W-1){1'b1}}};
    localparam int                      HOT_REGION    = 128;
    localparam int                      RANDOM_BEATS  = 1080;
    localparam int                      SETTLE_CYCLES = 64;

    logic                    i_clk         = 1'b0;
    logic                    i_rst_n       = 1'b0;
    logic                    i_valid       = 1'b0;
    logic                    o_ready;
    logic [FUNC_W-1:0]       i_func        = '0;
    logic [IDX_W-1:0]        i_entry_index = '0;
    logic signed [KEY_W-1:0] i_entry_key   = '0;
    logic [ROW_WIDTH-1:0]    i_entry_row   = '0;
    logic [POS_W-1:0]        i_range_low   = '0;
    logic [POS_W-1:0]        i_range_high  = '0;
    logic signed [KEY_W-1:0] i_pivot       = '0;
    logic                    o_valid;
    logic                    i_ready       = 1'b0;
    logic signed [KEY_W-1:0] o_read_key;
    logic [ROW_WIDTH-1:0]    o_read_row;
    logic [POS_W-1:0]        o_split_pos;

    int fail_count;
    int answers_pending;
    int beats_sent = 0;

    // Which store entries have been written so far.
    bit is_written [STORE_DEPTH];
    int written_list [$];

    crack_range_partition u_top (.*);

    crp_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_ready    (o_ready),
        .i_func        (i_func),
        .i_entry_index (i_entry_index),
        .i_entry_key   (i_entry_key),
        .i_entry_row   (i_entry_row),
        .i_range_low   (i_range_low),
        .i_range_high  (i_range_high),
        .i_pivot       (i_pivot),
        .i_out_valid   (o_valid),
        .i_out_ready   (i_ready),
        .i_read_key    (o_read_key),
        .i_read_row    (o_read_row),
        .i_split_pos   (o_split_pos),
        .o_fail_count  (fail_count),
        .o_pending     (answers_pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #10_000_000;
        $display("crack_range_partition regression: fail");
        $finish;
    end

    // Wait before a beat: none in every fourth stretch, otherwise none or a
    // random nonzero pause with equal odds.
    function automatic int pause_length(input int count, input int stretch);
        if ((count / stretch) % 4 == 3) begin
            return 0;
        end
        return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 16);
    endfunction

    // Keys and pivots: mostly small values so that comparisons split ranges,
    // with the extremes and full-width values mixed in.
    function automatic logic signed [KEY_W-1:0] draw_value();
        logic signed [KEY_W-1:0] v;
        int                      pick;
        int                      s;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            s = int'($urandom_range(0, 40)) - 20;
            v = KEY_W'(s);
        end else if (pick < 75) begin
            case ($urandom_range(0, 5))
                0:       v = KEY_MIN;
                1:       v = KEY_MAX;
                2:       v = KEY_MIN + 1;
                3:       v = KEY_MAX - 1;
                4:       v = '0;
                default: v = '1;
            endcase
        end else begin
            v = {$urandom, $urandom};
        end
        return v;
    endfunction

    // Sends one input beat. Fields that the function ignores carry noise.
    task automatic run_op(input logic [FUNC_W-1:0] func, input int index,
                          input logic signed [KEY_W-1:0] value,
                          input logic [ROW_WIDTH-1:0] row, input int lo, input int hi);
        t_item beat;
        int    gap;
        beat      = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        beat.func = func;
        if (func == FUNC_WRITE) begin
            beat.entry_index = IDX_W'(index);
            beat.entry_key   = value;
            beat.entry_row   = row;
            if (!is_written[index]) begin
                is_written[index] = 1'b1;
                written_list.push_back(index);
            end
        end else if (func == FUNC_READ) begin
            beat.entry_index = IDX_W'(index);
        end else if (func == FUNC_CRACK) begin
            beat.range_low  = POS_W'(lo);
            beat.range_high = POS_W'(hi);
            beat.pivot      = value;
        end
        gap = pause_length(beats_sent, 60);
        beats_sent++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_func        <= beat.func;
        i_entry_index <= beat.entry_index;
        i_entry_key   <= beat.entry_key;
        i_entry_row   <= beat.entry_row;
        i_range_low   <= beat.range_low;
        i_range_high  <= beat.range_high;
        i_pivot       <= beat.pivot;
        i_valid       <= 1'b1;
        do @(posedge i_clk); while (!(i_valid && o_ready));
    endtask

    // Result side: ready is held low for a drawn stall before each beat.
    initial begin : result_sink
        int stall;
        int taken;
        taken = 0;
        wait (i_rst_n);
        forever begin
            stall = pause_length(taken, 45);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_valid && i_ready));
            taken++;
        end
    end

    initial begin : stimulus
        int pick;
        int lo;
        int hi;
        int span;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: key and row extremes, a small block at the top of
        // the store, cracks with pivots at the lowest and highest key, a single
        // entry range, empty ranges and the unused function code.
        run_op(FUNC_WRITE, 0, KEY_MIN, 32'h0000_0000, 0, 0);
        run_op(FUNC_WRITE, 1, KEY_MAX, 32'hFFFF_FFFF, 0, 0);
        run_op(FUNC_WRITE, 2, 64'sd0, 32'h0000_0001, 0, 0);
        run_op(FUNC_WRITE, 3, -64'sd1, 32'h8000_0000, 0, 0);
        run_op(FUNC_WRITE, 1020, 64'sd5, $urandom, 0, 0);
        run_op(FUNC_WRITE, 1021, -64'sd3, $urandom, 0, 0);
        run_op(FUNC_WRITE, 1022, 64'sd7, $urandom, 0, 0);
        run_op(FUNC_WRITE, 1023, -64'sd3, $urandom, 0, 0);
        run_op(FUNC_READ, 0, '0, '0, 0, 0);
        run_op(FUNC_READ, 1, '0, '0, 0, 0);
        run_op(FUNC_READ, 1023, '0, '0, 0, 0);
        run_op(FUNC_CRACK, 0, 64'sd0, '0, 0, 3);
        run_op(FUNC_CRACK, 0, KEY_MIN, '0, 0, 3);
        run_op(FUNC_CRACK, 0, KEY_MAX, '0, 0, 3);
        run_op(FUNC_CRACK, 0, 64'sd0, '0, 1020, 1023);
        run_op(FUNC_CRACK, 0, 64'sd0, '0, 2, 2);
        run_op(FUNC_CRACK, 0, 64'sd0, '0, 1023, 0);
        run_op(FUNC_CRACK, 0, 64'sd0, '0, 1, 0);
        run_op(FUNC_UNUSED, 0, '0, '0, 0, 0);
        run_op(FUNC_READ, 0, '0, '0, 0, 0);
        run_op(FUNC_READ, 3, '0, '0, 0, 0);

        // Random part. Writes mostly land in a hot region so that long runs
        // of written entries form; cracks start on a written entry and
        // extend over written neighbours only, mostly over short spans.
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            pick = (written_list.size() < 8) ? 0 : $urandom_range(0, 99);
            if (pick < 35) begin
                lo = ($urandom_range(0, 4) != 0) ? $urandom_range(0, HOT_REGION - 1) :
                                                   $urandom_range(0, STORE_DEPTH - 1);
                run_op(FUNC_WRITE, lo, draw_value(), $urandom, 0, 0);
            end else if (pick < 55) begin
                lo = written_list[$urandom_range(0, written_list.size() - 1)];
                run_op(FUNC_READ, lo, '0, '0, 0, 0);
            end else if (pick < 88) begin
                lo   = written_list[$urandom_range(0, written_list.size() - 1)];
                span = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 16) :
                                                      $urandom_range(17, 128);
                hi   = lo;
                while (hi < STORE_DEPTH - 1 && hi - lo + 1 < span && is_written[hi + 1])
                    hi++;
                run_op(FUNC_CRACK, 0, draw_value(), '0, lo, hi);
            end else if (pick < 94) begin
                lo = $urandom_range(1, STORE_DEPTH - 1);
                hi = $urandom_range(0, lo - 1);
                run_op(FUNC_CRACK, 0, draw_value(), '0, lo, hi);
            end else begin
                run_op(FUNC_UNUSED, 0, '0, '0, 0, 0);
            end
        end
        i_valid <= 1'b0;

        // Drain: every answer must arrive, then nothing more may follow.
        @(posedge i_clk);
        wait (answers_pending == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("crack_range_partition regression: pass");
        end else begin
            $display("crack_range_partition regression: fail");
        end
        $finish;
    end

endmodule
